/* src/window_probe_drop_policy_macros.svh */
// ---------------------------------------------------------------------------
// window_probe_drop_policy_macros
// Assertion macros shared by the window probe drop policy block.
// ---------------------------------------------------------------------------
`ifndef WINDOW_PROBE_DROP_POLICY_MACROS_SVH
`define WINDOW_PROBE_DROP_POLICY_MACROS_SVH

// same-cycle implication
`define WPDP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WPDP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/wpdp_pkg.sv */
// ---------------------------------------------------------------------------
// wpdp_pkg
// Types and constants of the window probe drop policy block.
// ---------------------------------------------------------------------------
`default_nettype none

package wpdp_pkg;

   localparam int SEQ_W       = 32;
   localparam int COUNT_W     = 16;
   localparam int TOTAL_W     = 17;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_LIMIT   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EMU_DROP_INDEX = 8'd1;

   localparam logic [COUNT_W-1:0] ACCEPT_LIMIT_RST   = 16'd500;
   localparam logic [COUNT_W-1:0] EMU_DROP_INDEX_RST = 16'd10000;

   typedef enum logic [1:0] {
      ACT_PASS,
      ACT_ACCEPT,
      ACT_RETX,
      ACT_DROP
   } act_type;

   typedef struct packed {
      logic    load;
      logic    scan_start;
      logic    scan_run;
      logic    commit;
      act_type act;
   } wpdp_cmd_type;

   typedef struct packed {
      logic loss_hit;
      logic accept_phase;
      logic hit;
      logic scan_last;
   } wpdp_status_type;

endpackage

`default_nettype wire

/* src/window_probe_drop_policy.sv */
// Accept phase or loss sequence: start moves IDLE to CLASSIFY, which commits; the strobe is registered from the commit.
// Dropping phase: the drop list RAM is scanned one entry a cycle, and the strobe follows the
// commit on a hit at entry k or, for a miss, once all n stored entries have been read.
// A new start is taken in the strobe cycle, once the previous packet is committed.
// Reset (synchronous) clears counters, flags and results and loads the register defaults;
// the drop list is not cleared and there is no clearing pass. No stall on the result side.
`default_nettype none
`include "window_probe_drop_policy_macros.svh"

// ---------------------------------------------------------------------------
// window_probe_drop_policy
// Per-packet accept/drop verdict engine for probing a sender's window.
// ---------------------------------------------------------------------------
module window_probe_drop_policy #(
   parameter int DROP_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [wpdp_pkg::SEQ_W-1:0]       req_seq_number,
   output logic                             rsp_strobe,
   output logic                             rsp_drop,
   output logic                             rsp_finished,
   output logic [wpdp_pkg::TOTAL_W-1:0]     rsp_window_total,
   output logic                             rsp_list_full,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wpdp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wpdp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import wpdp_pkg::*;

   wpdp_cmd_type    cmd;
   wpdp_status_type status;

   assign csr_ready = 1'b1;

   wpdp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   wpdp_dpath #(
      .DROP_DEPTH (DROP_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg_we           (csr_valid && csr_ready),
      .cfg_index        (csr_index),
      .cfg_wdata        (csr_wdata),
      .seq_number       (req_seq_number),
      .rsp_drop         (rsp_drop),
      .rsp_finished     (rsp_finished),
      .rsp_window_total (rsp_window_total),
      .rsp_list_full    (rsp_list_full)
   );

   `WPDP_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy, "start not taken")
   `WPDP_ASSERT_NXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe, "back-to-back beat")
   `WPDP_ASSERT_IMP(a_full_drops, clock, reset, rsp_strobe && rsp_list_full, rsp_drop,
                    "list full without drop")
   `WPDP_ASSERT_IMP(a_commit_busy, clock, reset, cmd.commit, busy, "commit while idle")

endmodule

`default_nettype wire

/* src/wpdp_ram.sv */
// ---------------------------------------------------------------------------
// wpdp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module wpdp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/wpdp_ctrl.sv */
// ---------------------------------------------------------------------------
// wpdp_ctrl
// Sequencer: classifies each packet and steps the drop-list scan.
// ---------------------------------------------------------------------------
`default_nettype none

module wpdp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  wpdp_pkg::wpdp_status_type status,
   output wpdp_pkg::wpdp_cmd_type    cmd,
   output logic                      busy,
   output logic                      rsp_strobe
);

   import wpdp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.act        = ACT_PASS;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (status.loss_hit) begin
               cmd.commit = 1'b1;
               cmd.act    = ACT_PASS;
               state_in   = ST_IDLE;
            end else if (status.accept_phase) begin
               cmd.commit = 1'b1;
               cmd.act    = ACT_ACCEPT;
               state_in   = ST_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.scan_run = 1'b1;
            if (status.hit) begin
               cmd.commit = 1'b1;
               cmd.act    = ACT_RETX;
               state_in   = ST_IDLE;
            end else if (status.scan_last) begin
               cmd.commit = 1'b1;
               cmd.act    = ACT_DROP;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      strobe_in = cmd.commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

/* src/wpdp_dpath.sv */
// ---------------------------------------------------------------------------
// wpdp_dpath
// Counters, config registers, drop list and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module wpdp_dpath #(
   parameter int DROP_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wpdp_pkg::wpdp_cmd_type              cmd,
   output wpdp_pkg::wpdp_status_type           status,
   input  logic                                cfg_we,
   input  logic [wpdp_pkg::CSR_INDEX_W-1:0]    cfg_index,
   input  logic [wpdp_pkg::CSR_DATA_W-1:0]     cfg_wdata,
   input  logic [wpdp_pkg::SEQ_W-1:0]          seq_number,
   output logic                                rsp_drop,
   output logic                                rsp_finished,
   output logic [wpdp_pkg::TOTAL_W-1:0]        rsp_window_total,
   output logic                                rsp_list_full
);

   import wpdp_pkg::*;

   localparam int CNT_W  = $clog2(DROP_DEPTH + 1);
   localparam int ADDR_W = (DROP_DEPTH > 1) ? $clog2(DROP_DEPTH) : 1;

   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] emu_idx_ff, emu_idx_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [SEQ_W-1:0]   loss_ff, loss_in;
   logic [COUNT_W-1:0] accepted_ff, accepted_in;
   logic [CNT_W-1:0]   dropped_ff, dropped_in;
   logic               finished_ff, finished_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               drop_ff, drop_in;
   logic               full_ff, full_in;
   logic [CNT_W-1:0]   scan_ptr_ff, scan_ptr_in;
   logic               cmp_valid_ff, cmp_valid_in;

   logic               issue;
   logic               list_is_full;
   logic               ram_we;
   logic [SEQ_W-1:0]   rd_data;

   assign issue        = (scan_ptr_ff < dropped_ff);
   assign list_is_full = (dropped_ff >= CNT_W'(DROP_DEPTH));
   assign ram_we       = cmd.commit && (cmd.act == ACT_DROP) && !list_is_full;

   assign status.loss_hit     = (seq_ff == loss_ff);
   assign status.accept_phase = (accepted_ff < limit_ff);
   assign status.hit          = cmp_valid_ff && (rd_data == seq_ff);
   assign status.scan_last    = !issue;

   wpdp_ram #(
      .WIDTH (SEQ_W),
      .DEPTH (DROP_DEPTH)
   ) u_drop_list (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (dropped_ff[ADDR_W-1:0]),
      .wr_data (seq_ff),
      .rd_addr (scan_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      limit_in     = limit_ff;
      emu_idx_in   = emu_idx_ff;
      seq_in       = seq_ff;
      loss_in      = loss_ff;
      accepted_in  = accepted_ff;
      dropped_in   = dropped_ff;
      finished_in  = finished_ff;
      total_in     = total_ff;
      drop_in      = drop_ff;
      full_in      = full_ff;
      scan_ptr_in  = scan_ptr_ff;
      cmp_valid_in = cmp_valid_ff;

      if (cfg_we) begin
         case (cfg_index)
            CSR_ACCEPT_LIMIT:   limit_in   = cfg_wdata;
            CSR_EMU_DROP_INDEX: emu_idx_in = cfg_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         seq_in = seq_number;
      end

      if (cmd.scan_start) begin
         scan_ptr_in  = '0;
         cmp_valid_in = 1'b0;
      end else if (cmd.scan_run) begin
         if (issue) begin
            scan_ptr_in = scan_ptr_ff + CNT_W'(1);
         end
         cmp_valid_in = issue;
      end

      if (cmd.commit) begin
         case (cmd.act)
            ACT_PASS: begin
               drop_in = 1'b0;
               full_in = 1'b0;
            end
            ACT_ACCEPT: begin
               drop_in     = (accepted_ff == emu_idx_ff);
               full_in     = 1'b0;
               accepted_in = accepted_ff + COUNT_W'(1);
               if (accepted_ff == emu_idx_ff) begin
                  loss_in = seq_ff;
               end
            end
            ACT_RETX: begin
               drop_in     = 1'b0;
               full_in     = 1'b0;
               finished_in = 1'b1;
               total_in    = TOTAL_W'(accepted_ff) + TOTAL_W'(dropped_ff);
            end
            ACT_DROP: begin
               drop_in = 1'b1;
               full_in = list_is_full;
               if (!list_is_full) begin
                  dropped_in = dropped_ff + CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ACCEPT_LIMIT_RST;
         emu_idx_ff   <= EMU_DROP_INDEX_RST;
         loss_ff      <= '0;
         accepted_ff  <= '0;
         dropped_ff   <= '0;
         finished_ff  <= 1'b0;
         total_ff     <= '0;
         drop_ff      <= 1'b0;
         full_ff      <= 1'b0;
         scan_ptr_ff  <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         emu_idx_ff   <= emu_idx_in;
         loss_ff      <= loss_in;
         accepted_ff  <= accepted_in;
         dropped_ff   <= dropped_in;
         finished_ff  <= finished_in;
         total_ff     <= total_in;
         drop_ff      <= drop_in;
         full_ff      <= full_in;
         scan_ptr_ff  <= scan_ptr_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
   end

   assign rsp_drop         = drop_ff;
   assign rsp_finished     = finished_ff;
   assign rsp_window_total = total_ff;
   assign rsp_list_full    = full_ff;

endmodule

`default_nettype wire
